// ===== rtl/busdec_pkg.sv =====
// shared types, register indexes and the system area lookup of the bus address decoder
package busdec_pkg;

  typedef enum logic [3:0] {
    UNIT_WRAM     = 4'd0,
    UNIT_PORT     = 4'd1,
    UNIT_VIDEO    = 4'd2,
    UNIT_AUDIO    = 4'd3,
    UNIT_DMA      = 4'd4,
    UNIT_MATH     = 4'd5,
    UNIT_IRQ      = 4'd6,
    UNIT_ROM      = 4'd7,
    UNIT_SRAM     = 4'd8,
    UNIT_INTERNAL = 4'd9,
    UNIT_JOY      = 4'd10
  } unit_t;

  typedef enum logic [2:0] {
    ST_FORWARDED   = 3'd0,
    ST_INTERNAL    = 3'd1,
    ST_SRAM_ABSENT = 3'd2,
    ST_UNMAPPED    = 3'd3,
    ST_WRONG_DIR   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TIM_RAM     = 2'd0,
    TIM_IO_FAST = 2'd1,
    TIM_IO_SLOW = 2'd2,
    TIM_ROM     = 2'd3
  } timing_t;

  // allowed directions: bit 0 read, bit 1 write
  localparam logic [1:0] ACC_R  = 2'b01;
  localparam logic [1:0] ACC_W  = 2'b10;
  localparam logic [1:0] ACC_RW = 2'b11;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 4;

  localparam logic [CfgIdxW-1:0] CFG_MAP_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FAST_ROM     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SRAM_PRESENT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RAM_CYC      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IO_FAST_CYC  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_IO_SLOW_CYC  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_ROM_FAST_CYC = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_ROM_SLOW_CYC = 3'd7;

  typedef struct packed {
    logic       map_mode;
    logic       fast_rom;
    logic       sram_present;
    logic [3:0] ram_cycles;
    logic [3:0] io_fast_cycles;
    logic [3:0] io_slow_cycles;
    logic [3:0] rom_fast_cycles;
    logic [3:0] rom_slow_cycles;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    unit_t      unit;
    logic [1:0] acc;
    timing_t    timing;
  } sys_hit_t;

  typedef struct packed {
    logic [3:0]  target_unit;
    logic [23:0] local_address;
    logic [7:0]  bus_data;
    logic [3:0]  access_cycles;
    logic [2:0]  status;
  } res_t;

  // system area of banks 0x00-0x3f below 0x8000, by offset alone
  function automatic sys_hit_t sys_lookup(input logic [15:0] off);
    sys_hit_t r;
    r = '{hit: 1'b1, unit: UNIT_WRAM, acc: ACC_RW, timing: TIM_RAM};
    case (off) inside
      [16'h0000:16'h1FFF]: r = '{1'b1, UNIT_WRAM, ACC_RW, TIM_RAM};
      16'h2180:            r = '{1'b1, UNIT_PORT, ACC_RW, TIM_RAM};
      [16'h2181:16'h2183]: r = '{1'b1, UNIT_PORT, ACC_W, TIM_RAM};
      [16'h2100:16'h2133]: r = '{1'b1, UNIT_VIDEO, ACC_W, TIM_IO_FAST};
      [16'h2134:16'h213F]: r = '{1'b1, UNIT_VIDEO, ACC_R, TIM_IO_FAST};
      [16'h2140:16'h217F]: r = '{1'b1, UNIT_AUDIO, ACC_RW, TIM_IO_FAST};
      [16'h4300:16'h437F]: r = '{1'b1, UNIT_DMA, ACC_RW, TIM_IO_FAST};
      [16'h420B:16'h420C]: r = '{1'b1, UNIT_DMA, ACC_RW, TIM_IO_FAST};
      [16'h4202:16'h4206]: r = '{1'b1, UNIT_MATH, ACC_W, TIM_IO_FAST};
      [16'h4214:16'h4217]: r = '{1'b1, UNIT_MATH, ACC_R, TIM_IO_FAST};
      16'h4200:            r = '{1'b1, UNIT_IRQ, ACC_RW, TIM_IO_FAST};
      [16'h4207:16'h420A]: r = '{1'b1, UNIT_IRQ, ACC_RW, TIM_IO_FAST};
      [16'h4210:16'h4212]: r = '{1'b1, UNIT_IRQ, ACC_RW, TIM_IO_FAST};
      16'h420D:            r = '{1'b1, UNIT_INTERNAL, ACC_RW, TIM_IO_FAST};
      [16'h4016:16'h4017]: r = '{1'b1, UNIT_JOY, ACC_RW, TIM_IO_SLOW};
      16'h4201:            r = '{1'b1, UNIT_JOY, ACC_RW, TIM_IO_FAST};
      16'h4213:            r = '{1'b1, UNIT_JOY, ACC_RW, TIM_IO_FAST};
      [16'h4218:16'h421F]: r = '{1'b1, UNIT_JOY, ACC_RW, TIM_IO_FAST};
      default:             r = '{1'b0, UNIT_WRAM, ACC_RW, TIM_RAM};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/busdec_decode.sv =====
// combinational decode of one bus access: unit, direction check, local address, cycles
module busdec_decode (
  input  busdec_pkg::cfg_t cfg,
  input  logic             cmd,
  input  logic [23:0]      address,
  input  logic [7:0]       write_data,
  output busdec_pkg::res_t res
);

  logic [7:0]           bank;
  logic [15:0]          off;
  logic [7:0]           tb;
  busdec_pkg::sys_hit_t sys;
  logic                 mapped;
  busdec_pkg::unit_t    unit;
  logic [1:0]           acc;
  busdec_pkg::timing_t  tim;
  logic                 dir_ok;
  logic [7:0]           rom_bank;
  logic [23:0]          local_addr;
  logic [3:0]           cyc;

  assign bank = address[23:16];
  assign off  = address[15:0];
  // banks 0x80-0xfd mirror 0x00-0x7d
  assign tb   = (bank >= 8'h80 && bank <= 8'hFD) ? {1'b0, bank[6:0]} : bank;
  assign sys  = busdec_pkg::sys_lookup(off);

  always_comb begin
    mapped = 1'b1;
    unit   = busdec_pkg::UNIT_ROM;
    acc    = busdec_pkg::ACC_R;
    tim    = busdec_pkg::TIM_ROM;
    if (tb <= 8'h3F && !off[15]) begin
      if (sys.hit) begin
        unit = sys.unit;
        acc  = sys.acc;
        tim  = sys.timing;
      end else if (cfg.map_mode && tb >= 8'h20 && off >= 16'h6000) begin
        unit = busdec_pkg::UNIT_SRAM;
        acc  = busdec_pkg::ACC_RW;
        tim  = busdec_pkg::TIM_RAM;
      end else begin
        mapped = 1'b0;
      end
    end else if (tb == 8'h7E || tb == 8'h7F) begin
      unit = busdec_pkg::UNIT_WRAM;
      acc  = busdec_pkg::ACC_RW;
      tim  = busdec_pkg::TIM_RAM;
    end else if (!cfg.map_mode && tb >= 8'h70 && !off[15]) begin
      unit = busdec_pkg::UNIT_SRAM;
      acc  = busdec_pkg::ACC_RW;
      tim  = busdec_pkg::TIM_RAM;
    end
  end

  assign dir_ok = cmd ? acc[1] : acc[0];

  // low-rom banks 0xfe/0xff continue after bank 0x7d
  assign rom_bank = (tb >= 8'hFE) ? (tb - 8'h80) : tb;

  always_comb begin
    case (unit)
      busdec_pkg::UNIT_WRAM: local_addr = {7'b0, (tb == 8'h7F), off};
      busdec_pkg::UNIT_ROM: begin
        if (!cfg.map_mode) begin
          local_addr = {1'b0, rom_bank, off[14:0]};
        end else if (tb <= 8'h3F) begin
          local_addr = {tb, off};
        end else if (tb <= 8'h7D) begin
          local_addr = {tb - 8'h40, off};
        end else begin
          local_addr = {tb - 8'hC0, off};
        end
      end
      busdec_pkg::UNIT_SRAM: begin
        if (!cfg.map_mode) begin
          local_addr = {5'b0, tb[3:0], off[14:0]};
        end else begin
          local_addr = {6'b0, tb[4:0], off[12:0]};
        end
      end
      busdec_pkg::UNIT_MATH,
      busdec_pkg::UNIT_INTERNAL: local_addr = {tb, off};
      default: local_addr = {8'b0, off};
    endcase
  end

  always_comb begin
    case (tim)
      busdec_pkg::TIM_RAM:     cyc = cfg.ram_cycles;
      busdec_pkg::TIM_IO_FAST: cyc = cfg.io_fast_cycles;
      busdec_pkg::TIM_IO_SLOW: cyc = cfg.io_slow_cycles;
      default:                 cyc = cfg.fast_rom ? cfg.rom_fast_cycles : cfg.rom_slow_cycles;
    endcase
  end

  always_comb begin
    res.target_unit   = unit;
    res.local_address = 24'b0;
    res.bus_data      = 8'b0;
    res.access_cycles = 4'b0;
    res.status        = busdec_pkg::ST_FORWARDED;
    if (!mapped) begin
      res.target_unit = busdec_pkg::UNIT_WRAM;
      res.status      = busdec_pkg::ST_UNMAPPED;
    end else if (!dir_ok) begin
      res.status = busdec_pkg::ST_WRONG_DIR;
    end else begin
      res.local_address = local_addr;
      res.access_cycles = cyc;
      if (unit == busdec_pkg::UNIT_INTERNAL) begin
        res.status   = busdec_pkg::ST_INTERNAL;
        // speed register reads back the fast rom bit, writes are ignored
        res.bus_data = cmd ? 8'b0 : {7'b0, cfg.fast_rom};
      end else if (unit == busdec_pkg::UNIT_SRAM && !cfg.sram_present) begin
        res.status = busdec_pkg::ST_SRAM_ABSENT;
      end else begin
        res.bus_data = cmd ? write_data : 8'b0;
      end
    end
  end

endmodule

// ===== rtl/bus_address_decoder_unit.sv =====
// top level of the bus address decoder: configuration, input and result registers
// result path: a transfer taken by the input registers is decoded and shown with out_valid
//   high from the result registers
// throughput: one access per cycle, busy is never raised; set by the single decode stage
// reset (rst_n low, synchronous): configuration to its defaults, both stages emptied
module bus_address_decoder_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [23:0]                       in_address,
  input  logic [7:0]                        in_write_data,
  output logic                              out_valid,
  output logic [3:0]                        out_target_unit,
  output logic [23:0]                       out_local_address,
  output logic [7:0]                        out_bus_data,
  output logic [3:0]                        out_access_cycles,
  output logic [2:0]                        out_status,
  input  logic                              cfg_we,
  input  logic [busdec_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [busdec_pkg::CfgDataW-1:0]   cfg_data
);

  busdec_pkg::cfg_t cfg_r;
  logic             in_vld_r;
  logic             cmd_r;
  logic [23:0]      addr_r;
  logic [7:0]       wdata_r;
  logic             out_vld_r;
  busdec_pkg::res_t res_nxt;
  busdec_pkg::res_t res_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.map_mode        <= 1'b0;
      cfg_r.fast_rom        <= 1'b0;
      cfg_r.sram_present    <= 1'b0;
      cfg_r.ram_cycles      <= 4'd8;
      cfg_r.io_fast_cycles  <= 4'd6;
      cfg_r.io_slow_cycles  <= 4'd12;
      cfg_r.rom_fast_cycles <= 4'd6;
      cfg_r.rom_slow_cycles <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        busdec_pkg::CFG_MAP_MODE:     cfg_r.map_mode        <= cfg_data[0];
        busdec_pkg::CFG_FAST_ROM:     cfg_r.fast_rom        <= cfg_data[0];
        busdec_pkg::CFG_SRAM_PRESENT: cfg_r.sram_present    <= cfg_data[0];
        busdec_pkg::CFG_RAM_CYC:      cfg_r.ram_cycles      <= cfg_data;
        busdec_pkg::CFG_IO_FAST_CYC:  cfg_r.io_fast_cycles  <= cfg_data;
        busdec_pkg::CFG_IO_SLOW_CYC:  cfg_r.io_slow_cycles  <= cfg_data;
        busdec_pkg::CFG_ROM_FAST_CYC: cfg_r.rom_fast_cycles <= cfg_data;
        busdec_pkg::CFG_ROM_SLOW_CYC: cfg_r.rom_slow_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage, a transfer is taken every cycle start is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r   <= in_cmd;
      addr_r  <= in_address;
      wdata_r <= in_write_data;
    end
  end

  busdec_decode u_decode (
    .cfg        (cfg_r),
    .cmd        (cmd_r),
    .address    (addr_r),
    .write_data (wdata_r),
    .res        (res_nxt)
  );

  // result stage, shown for exactly one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_target_unit   = res_r.target_unit;
  assign out_local_address = res_r.local_address;
  assign out_bus_data      = res_r.bus_data;
  assign out_access_cycles = res_r.access_cycles;
  assign out_status        = res_r.status;

endmodule

// ===== dv/bus_address_decoder_unit_test.sv =====
// self-checking testbench of the bus address decoder: directed and random accesses
`timescale 1ns / 1ps

module bus_address_decoder_unit_test;

  localparam int WatchdogLimit = 1000;
  localparam int PrintCap = 40;

  // expected decodes of accepted accesses, with the settings they see
  class decode_checker;
    busdec_pkg::cfg_t regs;
    busdec_pkg::res_t awaited_decodes[$];
    logic [23:0] awaited_addrs[$];
    int unsigned mismatches;

    function new();
      regs.map_mode = 1'b0;
      regs.fast_rom = 1'b0;
      regs.sram_present = 1'b0;
      regs.ram_cycles = 4'd8;
      regs.io_fast_cycles = 4'd6;
      regs.io_slow_cycles = 4'd12;
      regs.rom_fast_cycles = 4'd6;
      regs.rom_slow_cycles = 4'd8;
      mismatches = 0;
    endfunction

    function void write_reg(logic [busdec_pkg::CfgIdxW-1:0] idx,
                            logic [busdec_pkg::CfgDataW-1:0] val);
      case (idx)
        busdec_pkg::CFG_MAP_MODE: regs.map_mode = val[0];
        busdec_pkg::CFG_FAST_ROM: regs.fast_rom = val[0];
        busdec_pkg::CFG_SRAM_PRESENT: regs.sram_present = val[0];
        busdec_pkg::CFG_RAM_CYC: regs.ram_cycles = val;
        busdec_pkg::CFG_IO_FAST_CYC: regs.io_fast_cycles = val;
        busdec_pkg::CFG_IO_SLOW_CYC: regs.io_slow_cycles = val;
        busdec_pkg::CFG_ROM_FAST_CYC: regs.rom_fast_cycles = val;
        busdec_pkg::CFG_ROM_SLOW_CYC: regs.rom_slow_cycles = val;
        default: ;
      endcase
    endfunction

    // unit, direction and timing class of a folded bank and offset; 0 when unmapped
    function logic classify(input logic [7:0] tb, input logic [15:0] off,
                            output busdec_pkg::unit_t tgt, output logic [1:0] acc,
                            output busdec_pkg::timing_t tim);
      logic [7:0] e;
      logic hit;
      hit = 1'b1;
      e = {busdec_pkg::UNIT_ROM, busdec_pkg::ACC_R, busdec_pkg::TIM_ROM};
      if (tb <= 8'h3F && off <= 16'h7FFF) begin
        if (off <= 16'h1FFF)
          e = {busdec_pkg::UNIT_WRAM, busdec_pkg::ACC_RW, busdec_pkg::TIM_RAM};
        else if (off == 16'h2180)
          e = {busdec_pkg::UNIT_PORT, busdec_pkg::ACC_RW, busdec_pkg::TIM_RAM};
        else if (off inside {[16'h2181:16'h2183]})
          e = {busdec_pkg::UNIT_PORT, busdec_pkg::ACC_W, busdec_pkg::TIM_RAM};
        else if (off inside {[16'h2100:16'h2133]})
          e = {busdec_pkg::UNIT_VIDEO, busdec_pkg::ACC_W, busdec_pkg::TIM_IO_FAST};
        else if (off inside {[16'h2134:16'h213F]})
          e = {busdec_pkg::UNIT_VIDEO, busdec_pkg::ACC_R, busdec_pkg::TIM_IO_FAST};
        else if (off inside {[16'h2140:16'h217F]})
          e = {busdec_pkg::UNIT_AUDIO, busdec_pkg::ACC_RW, busdec_pkg::TIM_IO_FAST};
        else if (off inside {[16'h4300:16'h437F], [16'h420B:16'h420C]})
          e = {busdec_pkg::UNIT_DMA, busdec_pkg::ACC_RW, busdec_pkg::TIM_IO_FAST};
        else if (off inside {[16'h4202:16'h4206]})
          e = {busdec_pkg::UNIT_MATH, busdec_pkg::ACC_W, busdec_pkg::TIM_IO_FAST};
        else if (off inside {[16'h4214:16'h4217]})
          e = {busdec_pkg::UNIT_MATH, busdec_pkg::ACC_R, busdec_pkg::TIM_IO_FAST};
        else if (off inside {16'h4200, [16'h4207:16'h420A], [16'h4210:16'h4212]})
          e = {busdec_pkg::UNIT_IRQ, busdec_pkg::ACC_RW, busdec_pkg::TIM_IO_FAST};
        else if (off == 16'h420D)
          e = {busdec_pkg::UNIT_INTERNAL, busdec_pkg::ACC_RW, busdec_pkg::TIM_IO_FAST};
        else if (off inside {[16'h4016:16'h4017]})
          e = {busdec_pkg::UNIT_JOY, busdec_pkg::ACC_RW, busdec_pkg::TIM_IO_SLOW};
        else if (off inside {16'h4201, 16'h4213, [16'h4218:16'h421F]})
          e = {busdec_pkg::UNIT_JOY, busdec_pkg::ACC_RW, busdec_pkg::TIM_IO_FAST};
        else if (regs.map_mode && tb >= 8'h20 && off >= 16'h6000)
          e = {busdec_pkg::UNIT_SRAM, busdec_pkg::ACC_RW, busdec_pkg::TIM_RAM};
        else hit = 1'b0;
      end else if (tb == 8'h7E || tb == 8'h7F) begin
        e = {busdec_pkg::UNIT_WRAM, busdec_pkg::ACC_RW, busdec_pkg::TIM_RAM};
      end else if (!regs.map_mode && tb >= 8'h70 && off <= 16'h7FFF) begin
        e = {busdec_pkg::UNIT_SRAM, busdec_pkg::ACC_RW, busdec_pkg::TIM_RAM};
      end
      tgt = busdec_pkg::unit_t'(e[7:4]);
      acc = e[3:2];
      tim = busdec_pkg::timing_t'(e[1:0]);
      return hit;
    endfunction

    function busdec_pkg::res_t predict_decode(logic cmd, logic [23:0] addr, logic [7:0] wd);
      logic [7:0] bank, tb;
      logic [31:0] b, o, a;
      busdec_pkg::unit_t tgt;
      logic [1:0] acc;
      busdec_pkg::timing_t tim;
      busdec_pkg::res_t r;
      bank = addr[23:16];
      // banks 0x80-0xfd mirror 0x00-0x7d
      tb = (bank >= 8'h80 && bank <= 8'hFD) ? bank - 8'h80 : bank;
      b = {24'd0, tb};
      o = {16'd0, addr[15:0]};
      r = '0;
      if (!classify(tb, addr[15:0], tgt, acc, tim)) begin
        r.status = busdec_pkg::ST_UNMAPPED;
        return r;
      end
      r.target_unit = tgt;
      if ((acc & (cmd ? busdec_pkg::ACC_W : busdec_pkg::ACC_R)) == 2'b00) begin
        r.status = busdec_pkg::ST_WRONG_DIR;
        return r;
      end
      case (tim)
        busdec_pkg::TIM_RAM: r.access_cycles = regs.ram_cycles;
        busdec_pkg::TIM_IO_FAST: r.access_cycles = regs.io_fast_cycles;
        busdec_pkg::TIM_IO_SLOW: r.access_cycles = regs.io_slow_cycles;
        default: r.access_cycles = regs.fast_rom ? regs.rom_fast_cycles : regs.rom_slow_cycles;
      endcase
      case (tgt)
        busdec_pkg::UNIT_WRAM: a = (b >= 32'h7E) ? (b - 32'h7E) * 32'h10000 + o : o;
        busdec_pkg::UNIT_ROM: begin
          if (!regs.map_mode) begin
            if (b >= 32'hFE) a = (b - 32'hFE + 32'h7E) * 32'h8000 + o - 32'h8000;
            else if (o >= 32'h8000) a = b * 32'h8000 + o - 32'h8000;
            else a = b * 32'h8000 + o;
          end else if (b <= 32'h3F) begin
            a = (b << 16) + o;
          end else if (b <= 32'h7D) begin
            a = ((b - 32'h40) << 16) + o;
          end else begin
            a = ((b - 32'hC0) << 16) + o;
          end
        end
        busdec_pkg::UNIT_SRAM: begin
          if (!regs.map_mode)
            a = (b >= 32'hFE) ? (b - 32'hFE + 32'h0E) * 32'h8000 + o : (b - 32'h70) * 32'h8000 + o;
          else
            a = (b - 32'h20) * 32'h2000 + o - 32'h6000;
        end
        busdec_pkg::UNIT_MATH, busdec_pkg::UNIT_INTERNAL: a = (b << 16) | o;
        default: a = o;
      endcase
      r.local_address = a[23:0];
      if (tgt == busdec_pkg::UNIT_INTERNAL) begin
        r.status = busdec_pkg::ST_INTERNAL;
        r.bus_data = cmd ? 8'h00 : {7'd0, regs.fast_rom};
      end else if (tgt == busdec_pkg::UNIT_SRAM && !regs.sram_present) begin
        r.status = busdec_pkg::ST_SRAM_ABSENT;
      end else begin
        r.status = busdec_pkg::ST_FORWARDED;
        r.bus_data = cmd ? wd : 8'h00;
      end
      return r;
    endfunction

    function void note(logic cmd, logic [23:0] addr, logic [7:0] wd);
      awaited_decodes.insert(awaited_decodes.size(), predict_decode(cmd, addr, wd));
      awaited_addrs.insert(awaited_addrs.size(), addr);
    endfunction

    function int pending();
      return awaited_decodes.size();
    endfunction

    task report(string what);
      if (mismatches < PrintCap) $display("%0t mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check(busdec_pkg::res_t got);
      busdec_pkg::res_t want;
      logic [23:0] addr;
      if (awaited_decodes.size() == 0) begin
        report($sformatf("unexpected result unit %0d addr %h status %0d",
                         got.target_unit, got.local_address, got.status));
        return;
      end
      want = awaited_decodes.pop_front();
      addr = awaited_addrs.pop_front();
      if (got.target_unit !== want.target_unit)
        report($sformatf("%h target_unit %0d want %0d", addr, got.target_unit, want.target_unit));
      if (got.local_address !== want.local_address)
        report($sformatf("%h local_address %h want %h", addr, got.local_address,
                         want.local_address));
      if (got.bus_data !== want.bus_data)
        report($sformatf("%h bus_data %h want %h", addr, got.bus_data, want.bus_data));
      if (got.access_cycles !== want.access_cycles)
        report($sformatf("%h access_cycles %0d want %0d", addr, got.access_cycles,
                         want.access_cycles));
      if (got.status !== want.status)
        report($sformatf("%h status %0d want %0d", addr, got.status, want.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [23:0] in_address = '0;
  logic [7:0] in_write_data = '0;
  logic out_valid;
  logic [3:0] out_target_unit;
  logic [23:0] out_local_address;
  logic [7:0] out_bus_data;
  logic [3:0] out_access_cycles;
  logic [2:0] out_status;
  logic cfg_we = 1'b0;
  logic [busdec_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [busdec_pkg::CfgDataW-1:0] cfg_data = '0;

  decode_checker sb;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  bus_address_decoder_unit i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_cmd(in_cmd),
    .in_address(in_address),
    .in_write_data(in_write_data),
    .out_valid(out_valid),
    .out_target_unit(out_target_unit),
    .out_local_address(out_local_address),
    .out_bus_data(out_bus_data),
    .out_access_cycles(out_access_cycles),
    .out_status(out_status),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // sample every transfer on the pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check({out_target_unit, out_local_address, out_bus_data, out_access_cycles,
                  out_status});
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note(in_cmd, in_address, in_write_data);
      if (out_valid || cfg_we || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("bus_address_decoder_unit_test: errors");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // start stays high across back-to-back transfers
  task automatic send_access(input logic cmd, input logic [23:0] addr, input logic [7:0] wd);
    int gap;
    in_cmd <= cmd;
    in_address <= addr;
    in_write_data <= wd;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [busdec_pkg::CfgIdxW-1:0] idx,
                           input logic [busdec_pkg::CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input busdec_pkg::cfg_t c);
    write_reg(busdec_pkg::CFG_MAP_MODE, {3'b0, c.map_mode});
    write_reg(busdec_pkg::CFG_FAST_ROM, {3'b0, c.fast_rom});
    write_reg(busdec_pkg::CFG_SRAM_PRESENT, {3'b0, c.sram_present});
    write_reg(busdec_pkg::CFG_RAM_CYC, c.ram_cycles);
    write_reg(busdec_pkg::CFG_IO_FAST_CYC, c.io_fast_cycles);
    write_reg(busdec_pkg::CFG_IO_SLOW_CYC, c.io_slow_cycles);
    write_reg(busdec_pkg::CFG_ROM_FAST_CYC, c.rom_fast_cycles);
    write_reg(busdec_pkg::CFG_ROM_SLOW_CYC, c.rom_slow_cycles);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly system area and the banks around work RAM and battery RAM
  function automatic logic [23:0] random_address();
    int sel;
    logic [7:0] bank;
    logic [15:0] off;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      bank = 8'($urandom_range(0, 63)) | (8'($urandom_range(0, 1)) << 7);
      case ($urandom_range(0, 4))
        0: off = 16'h2100 + 16'($urandom_range(0, 255));
        1: off = 16'h4000 + 16'($urandom_range(0, 1023));
        2: off = 16'($urandom_range(0, 16'h7FFF));
        3: off = 16'h6000 + 16'($urandom_range(0, 16'h1FFF));
        default: off = 16'($urandom);
      endcase
      return {bank, off};
    end
    if (sel < 60) begin
      bank = 8'h70 + 8'($urandom_range(0, 15)) + (8'($urandom_range(0, 1)) << 7);
      return {bank, 16'($urandom)};
    end
    return 24'($urandom);
  endfunction

  initial begin
    busdec_pkg::cfg_t c;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // low-ROM map with the reset settings
    send_access(1'b0, 24'h000000, 8'h00);
    send_access(1'b1, 24'hFFFFFF, 8'hFF);  // ROM is read only
    send_access(1'b0, 24'hFFFFFF, 8'h00);
    send_access(1'b0, 24'h80420D, 8'h00);  // speed register read in a mirror bank
    send_access(1'b1, 24'h00420D, 8'hA5);  // speed register write ignored
    send_access(1'b0, 24'h002000, 8'h00);  // hole in the system area
    send_access(1'b1, 24'h002134, 8'h3C);  // video read-only register written
    send_access(1'b0, 24'h704000, 8'h00);  // battery RAM absent
    send_access(1'b1, 24'hFE0000, 8'h5A);
    send_access(1'b0, 24'h3F4214, 8'h00);  // math keeps the bank
    send_access(1'b1, 24'hBF4202, 8'h81);
    send_access(1'b0, 24'h7E1234, 8'h00);
    send_access(1'b1, 24'h7FFFFF, 8'h00);
    send_access(1'b0, 24'h004016, 8'h00);
    send_access(1'b0, 24'h408000, 8'h00);
    drain();

    // high-ROM map, battery RAM only in banks 0x20-0x3f
    c = '{map_mode: 1'b1, fast_rom: 1'b1, sram_present: 1'b1, ram_cycles: 4'd1,
          io_fast_cycles: 4'd2, io_slow_cycles: 4'd3, rom_fast_cycles: 4'd4,
          rom_slow_cycles: 4'd5};
    apply_settings(c);
    send_access(1'b0, 24'h206000, 8'h00);
    send_access(1'b1, 24'h3F7FFF, 8'hC3);
    send_access(1'b0, 24'h1F6000, 8'h00);
    send_access(1'b0, 24'h80420D, 8'h00);
    send_access(1'b0, 24'hC00000, 8'h00);
    send_access(1'b0, 24'hFEFFFF, 8'h00);
    send_access(1'b0, 24'h7DFFFF, 8'h00);
    send_access(1'b1, 24'h000000, 8'hFF);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 0) begin
        c = '0;
      end else if (p == 1) begin
        c = '1;
      end else begin
        c.map_mode = p[0];
        c.fast_rom = p[1];
        c.sram_present = p[2];
        c.ram_cycles = 4'($urandom);
        c.io_fast_cycles = 4'($urandom);
        c.io_slow_cycles = 4'($urandom);
        c.rom_fast_cycles = 4'($urandom);
        c.rom_slow_cycles = 4'($urandom);
      end
      apply_settings(c);
      no_gaps = (p == 3 || p == 6);
      for (int n = 0; n < 104; n++)
        send_access(1'($urandom), random_address(), 8'($urandom));
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) $display("bus_address_decoder_unit_test: clean");
    else $display("bus_address_decoder_unit_test: errors");
    $finish;
  end

endmodule
